### rtl/core/postfix_expression_evaluator_defines.svh
// Assertion macros shared by the postfix expression evaluator RTL.
// Users must have ports or signals named clock and reset in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pee_pkg.sv
// Shared types and constants of the postfix expression evaluator.
// Used by the controller, the datapath and the top level; no dependencies.
package pee_pkg;

   // Character codes recognized in the expression stream.
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Value taken for a pop from an empty stack, and reported at finish.
   localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_WAIT,
      ST_POP_LHS,
      ST_EXEC,
      ST_DIV_RUN
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PUSH_DIGIT,
      PUSH_ALU,
      PUSH_QUOT,
      PUSH_ZERO
   } push_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         pop_rhs;
      logic         pop_lhs;
      logic         push;
      push_sel_type push_sel;
      logic         set_div_zero;
      logic         div_start;
      logic         emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_finish;
      logic is_digit;
      logic is_oper;
      logic is_div;
      logic rhs_zero;
      logic rsp_busy;
      logic div_done;
   } dp_status_type;

endpackage

### rtl/core/pee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; instantiated by the datapath. The divisor is assumed nonzero.
module pee_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start_i,
   input  logic [31:0] dividend_i,
   input  logic [31:0] divisor_i,
   output logic        busy_o,
   output logic        done_o,
   output logic [31:0] quotient_o
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [32:0] shifted;
   logic [32:0] diff;
   logic        fits;

   // One restoring step: shift in the next dividend bit and try the subtract.
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = ~diff[32];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start_i) begin
         // Work on magnitudes; the sign is applied to the quotient at the end.
         rem_in  = '0;
         quo_in  = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
         den_in  = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
         neg_in  = dividend_i[31] ^ divisor_i[31];
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], fits};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy_o     = busy_ff;
   assign done_o     = done_ff;
   assign quotient_o = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

### rtl/core/pee_dp.sv
// Datapath of the postfix expression evaluator: operand stack memory, stack
// count, error flags, ALU, divider and result register. Uses pee_pkg, pee_div.
`include "postfix_expression_evaluator_defines.svh"

module pee_dp import pee_pkg::*; #(
   parameter int STACK_DEPTH = 100
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd_i,
   output dp_status_type status_o,
   input  logic          req_op_i,
   input  logic [7:0]    req_ch_i,
   input  logic          rsp_tready_i,
   output logic          rsp_valid_o,
   output logic [31:0]   rsp_value_o,
   output logic [2:0]    rsp_flags_o
);

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam int AddrWidth  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;

   logic                  op_ff, op_in;
   logic [7:0]            ch_ff, ch_in;
   logic [31:0]           rhs_ff, rhs_in;
   logic [31:0]           lhs_ff, lhs_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  underflow_ff, underflow_in;
   logic                  overflow_ff, overflow_in;
   logic                  div_zero_ff, div_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [2:0]            rsp_flags_ff, rsp_flags_in;

   logic                 empty;
   logic                 full;
   logic [AddrWidth-1:0] rd_addr;
   logic [AddrWidth-1:0] wr_addr;
   logic                 mem_we;
   logic [31:0]          top_value;
   logic [31:0]          alu_result;
   logic [31:0]          push_value;
   logic                 div_busy;
   logic                 div_done;
   logic [31:0]          div_quotient;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CountWidth'(STACK_DEPTH));
   assign top_value = empty ? EMPTY_VALUE : rd_data_ff;

   // The read port always follows the current top of stack.
   assign rd_addr = empty ? '0 : AddrWidth'(count_ff - 1'b1);
   assign wr_addr = AddrWidth'(count_ff);
   assign mem_we  = cmd_i.push && !full;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= push_value;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Add, subtract and multiply share one result; division has its own unit.
   always_comb begin
      unique case (ch_ff)
         CH_PLUS:  alu_result = lhs_ff + rhs_ff;
         CH_MINUS: alu_result = lhs_ff - rhs_ff;
         default:  alu_result = lhs_ff * rhs_ff;
      endcase
   end

   always_comb begin
      unique case (cmd_i.push_sel)
         PUSH_DIGIT: push_value = {28'd0, ch_ff[3:0]};
         PUSH_ALU:   push_value = alu_result;
         PUSH_QUOT:  push_value = div_quotient;
         PUSH_ZERO:  push_value = '0;
      endcase
   end

   pee_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (cmd_i.div_start),
      .dividend_i (lhs_ff),
      .divisor_i  (rhs_ff),
      .busy_o     (div_busy),
      .done_o     (div_done),
      .quotient_o (div_quotient)
   );

   // Item capture, operand pops, stack count and sticky flags.
   always_comb begin
      op_in        = op_ff;
      ch_in        = ch_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      count_in     = count_ff;
      underflow_in = underflow_ff;
      overflow_in  = overflow_ff;
      div_zero_in  = div_zero_ff;
      if (cmd_i.capture) begin
         op_in = req_op_i;
         ch_in = req_ch_i;
      end
      if (cmd_i.pop_rhs) begin
         rhs_in = top_value;
      end
      if (cmd_i.pop_lhs) begin
         lhs_in = top_value;
      end
      if (cmd_i.emit) begin
         count_in     = '0;
         underflow_in = 1'b0;
         overflow_in  = 1'b0;
         div_zero_in  = 1'b0;
      end else begin
         if (cmd_i.pop_rhs || cmd_i.pop_lhs) begin
            if (empty) begin
               underflow_in = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         if (cmd_i.push) begin
            if (full) begin
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         if (cmd_i.set_div_zero) begin
            div_zero_in = 1'b1;
         end
      end
   end

   // Result register: loaded at finish, emptied when the receiver takes it.
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_flags_in = rsp_flags_ff;
      if (cmd_i.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = top_value;
         rsp_flags_in = {div_zero_ff, overflow_ff, underflow_ff};
      end else if (rsp_tready_i) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      rhs_ff       <= rhs_in;
      lhs_ff       <= lhs_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         underflow_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         div_zero_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         underflow_ff <= underflow_in;
         overflow_ff  <= overflow_in;
         div_zero_ff  <= div_zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Decode of the held item and other status for the controller.
   always_comb begin
      status_o.is_finish = op_ff;
      status_o.is_digit  = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      status_o.is_oper   = (ch_ff == CH_PLUS) || (ch_ff == CH_MINUS) ||
                           (ch_ff == CH_STAR) || (ch_ff == CH_SLASH);
      status_o.is_div    = (ch_ff == CH_SLASH);
      status_o.rhs_zero  = (rhs_ff == '0);
      status_o.rsp_busy  = rsp_valid_ff && !rsp_tready_i;
      status_o.div_done  = div_done;
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_value_o = rsp_value_ff;
   assign rsp_flags_o = rsp_flags_ff;

   `PEE_ASSERT_NEXT(a_emit_clears, cmd_i.emit, (count_ff == '0) && rsp_valid_ff && !underflow_ff, "finish did not clear the stack or load the result")
   `PEE_ASSERT_NEXT(a_push_grows, cmd_i.push && !full && !cmd_i.emit, count_ff == $past(count_ff) + 1'b1, "push onto a non-full stack did not raise the count")
   `PEE_ASSERT_NEXT(a_div_runs, cmd_i.div_start, div_busy && !div_done, "divider did not start on command")

endmodule

### rtl/core/pee_ctrl.sv
// Controller of the postfix expression evaluator: sequences capture, pops,
// arithmetic, division and finish. Uses pee_pkg; drives the datapath.
module pee_ctrl import pee_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid_i,
   output logic          req_ready_o,
   input  dp_status_type status_i,
   output ctrl_cmd_type  cmd_o
);

   ctrl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid_i) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (status_i.is_finish) begin
               if (!status_i.rsp_busy) state_in = ST_IDLE;
            end else if (status_i.is_oper) begin
               state_in = ST_POP_WAIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_WAIT: state_in = ST_POP_LHS;
         ST_POP_LHS:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (status_i.is_div && !status_i.rhs_zero) begin
               state_in = ST_DIV_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_RUN: begin
            if (status_i.div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands for the datapath.
   always_comb begin
      req_ready_o = 1'b0;
      cmd_o       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready_o   = 1'b1;
            cmd_o.capture = req_valid_i;
         end
         ST_DISPATCH: begin
            priority if (status_i.is_finish) begin
               cmd_o.emit = !status_i.rsp_busy;
            end else if (status_i.is_digit) begin
               cmd_o.push     = 1'b1;
               cmd_o.push_sel = PUSH_DIGIT;
            end else if (status_i.is_oper) begin
               cmd_o.pop_rhs = 1'b1;
            end else begin
               cmd_o = '0;
            end
         end
         ST_POP_WAIT: cmd_o = '0;
         ST_POP_LHS:  cmd_o.pop_lhs = 1'b1;
         ST_EXEC: begin
            priority if (!status_i.is_div) begin
               cmd_o.push     = 1'b1;
               cmd_o.push_sel = PUSH_ALU;
            end else if (status_i.rhs_zero) begin
               cmd_o.push         = 1'b1;
               cmd_o.push_sel     = PUSH_ZERO;
               cmd_o.set_div_zero = 1'b1;
            end else begin
               cmd_o.div_start = 1'b1;
            end
         end
         ST_DIV_RUN: begin
            cmd_o.push     = status_i.div_done;
            cmd_o.push_sel = PUSH_QUOT;
         end
         default: cmd_o = '0;
      endcase
   end

endmodule

### rtl/core/postfix_expression_evaluator.sv
// Postfix (RPN) expression evaluator fed one character per word.
// An input word is either an expression character or a finish request.
// The block keeps an operand stack of STACK_DEPTH 32-bit entries.
// Digits push their value; + - * / pop two operands and push the result,
// wrapping in 32-bit two's complement, division truncating toward zero.
// A finish word returns one result word with the top of stack (-1 if empty)
// and the sticky underflow, overflow and divide-by-zero flags, then clears.
// A word is taken while idle and decoded in dispatch; an operator pops its
// right operand, then its left, and executes, a nonzero / running the
// one-bit-per-cycle divider. The result is valid in the cycle after finish.
// The result sits in an output register; while it waits, expression words
// keep being accepted, and only a later finish word waits for it to drain.
// Reset empties the stack, clears the flags and drops any pending result.
// The stack memory needs no clearing after reset.
// Uses pee_pkg, pee_ctrl, pee_dp.
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] op (1 = finish)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [2:0]  rsp_tuser    // [0] underflow, [1] overflow, [2] div_zero
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pee_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_tvalid),
      .req_ready_o (req_tready),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   pee_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .status_o     (status),
      .req_op_i     (req_tuser),
      .req_ch_i     (req_tdata),
      .rsp_tready_i (rsp_tready),
      .rsp_valid_o  (rsp_tvalid),
      .rsp_value_o  (rsp_tdata),
      .rsp_flags_o  (rsp_tuser)
   );

endmodule
